[rtl/core/spc_pkg.sv]
// Shared types, constants and the control program of the sprite pixel collision unit.
// Used by spc_mask_mem and sprite_pixel_collision_unit; depends on nothing.
`timescale 1ns / 1ps

package spc_pkg;

    localparam int MAX_SPRITE_W = 16;
    localparam int MAX_SPRITE_H = 16;
    localparam int WORD_W       = MAX_SPRITE_W;
    localparam int MEM_WORDS    = (MAX_SPRITE_W * MAX_SPRITE_H) / WORD_W;
    localparam int WADDR_W      = $clog2(MEM_WORDS);
    localparam int BIT_W        = $clog2(WORD_W);
    localparam int IDX_W        = 8;

    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;

    localparam logic [1:0] CFG_WIDTH_A  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT_A = 2'd1;
    localparam logic [1:0] CFG_WIDTH_B  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT_B = 2'd3;

    localparam logic [2:0] PC_WAIT  = 3'd0;
    localparam logic [2:0] PC_SETUP = 3'd1;
    localparam logic [2:0] PC_FIRST = 3'd2;
    localparam logic [2:0] PC_LOOP  = 3'd3;
    localparam logic [2:0] PC_EMIT  = 3'd4;

    localparam logic [1:0] COND_ALWAYS    = 2'd0;
    localparam logic [1:0] COND_START     = 2'd1;
    localparam logic [1:0] COND_MORE_ROWS = 2'd2;
    localparam logic [1:0] COND_OUT_FREE  = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       setup;
        logic       issue;
        logic       cmp;
        logic       emit;
        logic [1:0] cond;
        logic [2:0] jump;
        logic [2:0] next;
    } t_uword;

    function automatic t_uword ucode(input logic [2:0] pc);
        t_uword w;
        w = '0;
        case (pc)
            PC_WAIT: begin
                w.accept = 1'b1;
                w.cond   = COND_START;
                w.jump   = PC_SETUP;
                w.next   = PC_WAIT;
            end
            PC_SETUP: begin
                w.setup = 1'b1;
                w.cond  = COND_ALWAYS;
                w.jump  = PC_FIRST;
                w.next  = PC_FIRST;
            end
            PC_FIRST: begin
                w.issue = 1'b1;
                w.cond  = COND_ALWAYS;
                w.jump  = PC_LOOP;
                w.next  = PC_LOOP;
            end
            PC_LOOP: begin
                w.issue = 1'b1;
                w.cmp   = 1'b1;
                w.cond  = COND_MORE_ROWS;
                w.jump  = PC_LOOP;
                w.next  = PC_EMIT;
            end
            PC_EMIT: begin
                w.emit = 1'b1;
                w.cond = COND_OUT_FREE;
                w.jump = PC_WAIT;
                w.next = PC_EMIT;
            end
            default: begin
                w.cond = COND_ALWAYS;
                w.jump = PC_WAIT;
                w.next = PC_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

[rtl/core/spc_mask_mem.sv]
// Sprite mask memory: one bit written per load, two adjacent words read per cycle.
// Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_mask_mem (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [spc_pkg::IDX_W-1:0]     i_waddr,
    input  logic                          i_wdata,
    input  logic [spc_pkg::WADDR_W-1:0]   i_raddr,
    output logic [2*spc_pkg::WORD_W-1:0]  o_rdata
);

    logic [spc_pkg::WORD_W-1:0]  r_mem [spc_pkg::MEM_WORDS];
    logic [spc_pkg::WADDR_W-1:0] raddr_hi;

    assign raddr_hi = i_raddr + spc_pkg::WADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr[spc_pkg::IDX_W-1 -: spc_pkg::WADDR_W]]
                 [i_waddr[spc_pkg::BIT_W-1:0]] <= i_wdata;
        end
        o_rdata <= {r_mem[raddr_hi], r_mem[i_raddr]};
    end

endmodule

[rtl/core/sprite_pixel_collision_unit.sv]
// Top level of the sprite pixel collision unit: microcoded row sequencer and datapath.
// Depends on spc_pkg and spc_mask_mem.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (i_valid / o_ready) carries one item: op 0 or 1 loads one
//   pixel of sprite A or B at i_pixel_index, op 2 tests the two sprites at
//   the given screen positions, op 3 is dropped.
//   Output channel (o_valid / i_ready) returns one hit bit per test item.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the four size
//   registers; it is always ready and must only be used while idle.
// Timing:
//   Load items are taken back to back in the wait step. A test item runs
//   through the setup, first-issue, loop and emit steps before its result
//   is registered; the loop covers h rows, h being height_a clamped to
//   1..16, and compares one row of sprite A against the matching row of
//   sprite B per cycle, bound by the two-word read port of each mask memory.
//   Once the result is registered the sequencer returns to wait.
// Reset: sizes return to 1x1, the sequencer returns to wait, no result is
//   pending. Mask contents are not cleared and must be loaded before use.
// Stall: a held result blocks the next test at the emit step only.

module sprite_pixel_collision_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_op,
    input  logic [spc_pkg::IDX_W-1:0]     i_pixel_index,
    input  logic                          i_pixel_opaque,
    input  logic signed [9:0]             i_pos_ax,
    input  logic signed [9:0]             i_pos_ay,
    input  logic signed [9:0]             i_pos_bx,
    input  logic signed [9:0]             i_pos_by,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [4:0]                    i_cfg_data
);

    localparam int W = spc_pkg::WORD_W;

    logic [2:0]  r_pc, n_pc;
    spc_pkg::t_uword uw;
    logic        cond_ok;
    logic        take, start;

    logic [4:0]  r_cfg_wa, r_cfg_ha, r_cfg_wb, r_cfg_hb;
    logic [4:0]  r_wa, r_ha, r_wb, r_hb;
    logic [W-1:0] r_mask_a, r_mask_b;
    logic signed [10:0] r_dx, r_dy;
    logic        r_dx_neg, r_dx_far;
    logic [3:0]  r_dx_amt;

    logic [4:0]  r_ra;
    logic        r_row_vld;
    logic [spc_pkg::BIT_W-1:0] r_a_sh, r_b_sh;
    logic        r_hit;
    logic        r_o_valid, r_o_hit;

    logic [4:0]  wa_c, ha_c, wb_c, hb_c;
    logic [W-1:0] mask_a_c, mask_b_c;
    logic [10:0] dx_mag;

    logic signed [11:0] rb;
    logic        rb_ok, ra_ok;
    logic [7:0]  addr_a, addr_b;

    logic [2*W-1:0] a_rdata, b_rdata, a_cat_sh, b_cat_sh;
    logic [W-1:0] a_row, b_row, b_align;

    logic        we_a, we_b;

    function automatic logic [4:0] clamp_size(input logic [4:0] v, input logic [4:0] vmax);
        logic [4:0] r;
        r = v;
        if (v == 5'd0) begin
            r = 5'd1;
        end else if (v > vmax) begin
            r = vmax;
        end
        return r;
    endfunction

    function automatic logic [W-1:0] low_mask(input logic [4:0] n);
        logic [W-1:0] m;
        for (int i = 0; i < W; i++) begin
            m[i] = (5'(i) < n);
        end
        return m;
    endfunction

    assign uw      = spc_pkg::ucode(r_pc);
    assign o_ready = uw.accept;
    assign take    = i_valid && uw.accept;
    assign start   = take && (i_op == spc_pkg::OP_TEST);
    assign we_a    = take && (i_op == spc_pkg::OP_LOAD_A);
    assign we_b    = take && (i_op == spc_pkg::OP_LOAD_B);

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_hit       = r_o_hit;

    always_comb begin
        case (uw.cond)
            spc_pkg::COND_ALWAYS:    cond_ok = 1'b1;
            spc_pkg::COND_START:     cond_ok = start;
            spc_pkg::COND_MORE_ROWS: cond_ok = (r_ra < r_ha);
            spc_pkg::COND_OUT_FREE:  cond_ok = !r_o_valid || i_ready;
            default:                 cond_ok = 1'b1;
        endcase
        n_pc = cond_ok ? uw.jump : uw.next;
    end

    // setup values
    always_comb begin
        wa_c     = clamp_size(r_cfg_wa, 5'(spc_pkg::MAX_SPRITE_W));
        ha_c     = clamp_size(r_cfg_ha, 5'(spc_pkg::MAX_SPRITE_H));
        wb_c     = clamp_size(r_cfg_wb, 5'(spc_pkg::MAX_SPRITE_W));
        hb_c     = clamp_size(r_cfg_hb, 5'(spc_pkg::MAX_SPRITE_H));
        mask_a_c = low_mask(wa_c);
        mask_b_c = low_mask(wb_c);
        dx_mag   = r_dx[10] ? 11'(-r_dx) : 11'(r_dx);
    end

    // row issue
    always_comb begin
        rb     = $signed({7'd0, r_ra}) + $signed({r_dy[10], r_dy});
        rb_ok  = !rb[11] && (rb[10:0] < {6'd0, r_hb});
        ra_ok  = (r_ra < r_ha);
        addr_a = {4'd0, r_ra[3:0]} * {3'd0, r_wa};
        addr_b = {4'd0, rb[3:0]} * {3'd0, r_wb};
    end

    // row compare
    always_comb begin
        a_cat_sh = a_rdata >> r_a_sh;
        b_cat_sh = b_rdata >> r_b_sh;
        a_row    = a_cat_sh[W-1:0] & r_mask_a;
        b_row    = b_cat_sh[W-1:0] & r_mask_b;
        if (r_dx_far) begin
            b_align = '0;
        end else if (r_dx_neg) begin
            b_align = b_row << r_dx_amt;
        end else begin
            b_align = b_row >> r_dx_amt;
        end
    end

    spc_mask_mem u_mask_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (i_pixel_index),
        .i_wdata (i_pixel_opaque),
        .i_raddr (addr_a[7:4]),
        .o_rdata (a_rdata)
    );

    spc_mask_mem u_mask_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (i_pixel_index),
        .i_wdata (i_pixel_opaque),
        .i_raddr (addr_b[7:4]),
        .o_rdata (b_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= spc_pkg::PC_WAIT;
            r_o_valid <= 1'b0;
            r_cfg_wa  <= 5'd1;
            r_cfg_ha  <= 5'd1;
            r_cfg_wb  <= 5'd1;
            r_cfg_hb  <= 5'd1;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    spc_pkg::CFG_WIDTH_A:  r_cfg_wa <= i_cfg_data;
                    spc_pkg::CFG_HEIGHT_A: r_cfg_ha <= i_cfg_data;
                    spc_pkg::CFG_WIDTH_B:  r_cfg_wb <= i_cfg_data;
                    spc_pkg::CFG_HEIGHT_B: r_cfg_hb <= i_cfg_data;
                    default: ;
                endcase
            end
            if (uw.emit && cond_ok) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_dx <= $signed({i_pos_ax[9], i_pos_ax}) - $signed({i_pos_bx[9], i_pos_bx});
            r_dy <= $signed({i_pos_ay[9], i_pos_ay}) - $signed({i_pos_by[9], i_pos_by});
        end
        if (uw.setup) begin
            r_wa     <= wa_c;
            r_ha     <= ha_c;
            r_wb     <= wb_c;
            r_hb     <= hb_c;
            r_mask_a <= mask_a_c;
            r_mask_b <= mask_b_c;
            r_dx_neg <= r_dx[10];
            r_dx_far <= (dx_mag > 11'(W - 1));
            r_dx_amt <= dx_mag[3:0];
            r_ra     <= 5'd0;
            r_hit    <= 1'b0;
        end
        if (uw.issue) begin
            r_row_vld <= ra_ok && rb_ok;
            r_a_sh    <= addr_a[spc_pkg::BIT_W-1:0];
            r_b_sh    <= addr_b[spc_pkg::BIT_W-1:0];
            r_ra      <= r_ra + 5'd1;
        end
        if (uw.cmp && r_row_vld && (|(a_row & b_align))) begin
            r_hit <= 1'b1;
        end
        if (uw.emit && cond_ok) begin
            r_o_hit <= r_hit;
        end
    end

endmodule
